// File: hdl/sfdi_pkg.sv
// Package for the stereo interpolated feedback delay: sizes, fixed-point
// constants, command and status structs, controller states and helpers.
// Depends on nothing; every other file of the block but sfdi_ram uses it.
`default_nettype none
package sfdi_pkg;

  localparam int BufferDepth = 65536;
  localparam int SampleBits  = 24;
  localparam int AddrW       = $clog2(BufferDepth);
  localparam int LenW        = AddrW + 1;
  localparam int FracW       = 24;
  localparam int SmW         = 40;
  localparam int PosW        = ((LenW + FracW) > SmW ? (LenW + FracW) : SmW) + 1;
  localparam int CfgW        = 24;

  // Smoother coefficient, round(0.0001 * 2^32).
  localparam logic [18:0] SmoothK     = 19'd429497;
  localparam logic [14:0] FeedbackMax = 15'd32113;
  localparam logic [15:0] MixFull     = 16'd32768;

  localparam logic [15:0] DryWetReset      = 16'd16384;
  localparam logic [14:0] FeedbackReset    = 15'd16384;
  localparam logic [23:0] DelayTargetReset = 24'd12288000;
  localparam logic [16:0] BufferLenReset   = 17'd65536;

  typedef enum logic [1:0] {
    CfgDryWet    = 2'd0,
    CfgFeedback  = 2'd1,
    CfgDelay     = 2'd2,
    CfgBufferLen = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StWrite,
    StMulHi,
    StStep,
    StSmooth,
    StPos,
    StReadA,
    StReadB,
    StInterp,
    StDelayed,
    StMix,
    StFinish
  } state_e;

  typedef struct packed {
    logic             clr_we;
    logic [AddrW-1:0] clr_addr;
    logic             load;
    logic             wr;
    logic             mul_hi;
    logic             step;
    logic             smooth;
    logic             pos;
    logic             rda;
    logic             rdb;
    logic             intp;
    logic             dly;
    logic             mix;
    logic             fin;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // Saturate a widened sample to SampleBits.
  function automatic logic signed [SampleBits-1:0] sat_fn(
      input logic signed [SampleBits+3:0] v);
    logic signed [SampleBits+3:0] hi;
    logic signed [SampleBits+3:0] lo;
    hi = {{5{1'b0}}, {(SampleBits-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[SampleBits-1:0];
    end else if (v < lo) begin
      return lo[SampleBits-1:0];
    end
    return v[SampleBits-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hdl/stereo_feedback_delay_interpolated_top.sv
// Top level of the stereo feedback delay with fractional, smoothed delay time.
// Joins sfdi_ctrl and sfdi_dp; uses sfdi_pkg.
//
//   Channel   Signals                                   Direction
//   input     in_valid_i, in_stall_o, left/right_in_i   one stereo beat in
//   output    out_valid_o, out_stall_i, left/right_out_o one mixed beat out
//   config    cfg_we_i, cfg_idx_i, cfg_data_i           register write
//
// For each beat, from acceptance until the input is free again, the
// controller steps through the delay-line write, two partial products
// of the smoother, the read-position update, two reads of the single
// read port of each delay-line RAM, interpolation and the mix.
// After reset both delay lines are cleared, one entry per cycle, all
// BufferDepth (65536) entries, before the first beat is accepted.
// A finished beat sits in an output register; a new input beat is accepted
// while it waits, and only the last step stalls until that register is free.
`default_nettype none
module stereo_feedback_delay_interpolated_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [sfdi_pkg::SampleBits-1:0] left_in_i,
  input  wire logic signed [sfdi_pkg::SampleBits-1:0] right_in_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [sfdi_pkg::SampleBits-1:0]   left_out_o,
  output logic signed [sfdi_pkg::SampleBits-1:0]   right_out_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [1:0]                          cfg_idx_i,
  input  wire logic [sfdi_pkg::CfgW-1:0]           cfg_data_i
);

  sfdi_pkg::cmd_t    cmd;
  sfdi_pkg::status_t status;

  sfdi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sfdi_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o)
  );

endmodule
`default_nettype wire

// File: hdl/sfdi_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for both delay lines.
`default_nettype none
module sfdi_ram #(
  parameter int Width = 24,
  parameter int Depth = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: hdl/sfdi_ctrl.sv
// Controller of the feedback delay: clearing pass after reset and the
// per-beat sequence of datapath commands. Uses sfdi_pkg.
`default_nettype none
module sfdi_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire sfdi_pkg::status_t status_i,
  output sfdi_pkg::cmd_t         cmd_o
);

  sfdi_pkg::state_e             state_q, state_d;
  logic [sfdi_pkg::AddrW-1:0]   clr_cnt_q, clr_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sfdi_pkg::StClear;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    cmd_o     = '0;
    cmd_o.clr_addr = clr_cnt_q;
    in_stall_o = 1'b1;
    case (state_q)
      sfdi_pkg::StClear: begin
        cmd_o.clr_we = 1'b1;
        clr_cnt_d    = clr_cnt_q + 1'b1;
        if (&clr_cnt_q) begin
          state_d = sfdi_pkg::StIdle;
        end
      end
      sfdi_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sfdi_pkg::StWrite;
        end
      end
      sfdi_pkg::StWrite: begin
        cmd_o.wr = 1'b1;
        state_d  = sfdi_pkg::StMulHi;
      end
      sfdi_pkg::StMulHi: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = sfdi_pkg::StStep;
      end
      sfdi_pkg::StStep: begin
        cmd_o.step = 1'b1;
        state_d    = sfdi_pkg::StSmooth;
      end
      sfdi_pkg::StSmooth: begin
        cmd_o.smooth = 1'b1;
        state_d      = sfdi_pkg::StPos;
      end
      sfdi_pkg::StPos: begin
        cmd_o.pos = 1'b1;
        state_d   = sfdi_pkg::StReadA;
      end
      sfdi_pkg::StReadA: begin
        cmd_o.rda = 1'b1;
        state_d   = sfdi_pkg::StReadB;
      end
      sfdi_pkg::StReadB: begin
        cmd_o.rdb = 1'b1;
        state_d   = sfdi_pkg::StInterp;
      end
      sfdi_pkg::StInterp: begin
        cmd_o.intp = 1'b1;
        state_d    = sfdi_pkg::StDelayed;
      end
      sfdi_pkg::StDelayed: begin
        cmd_o.dly = 1'b1;
        state_d   = sfdi_pkg::StMix;
      end
      sfdi_pkg::StMix: begin
        cmd_o.mix = 1'b1;
        state_d   = sfdi_pkg::StFinish;
      end
      sfdi_pkg::StFinish: begin
        if (status_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = sfdi_pkg::StIdle;
        end
      end
      default: begin
        state_d = sfdi_pkg::StIdle;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/sfdi_dp.sv
// Datapath of the feedback delay: configuration registers, delay-line RAMs,
// smoother, read position, interpolation, feedback and mix. Uses sfdi_pkg
// and sfdi_ram.
`default_nettype none
module sfdi_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire sfdi_pkg::cmd_t                      cmd_i,
  output sfdi_pkg::status_t                        status_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [1:0]                          cfg_idx_i,
  input  wire logic [sfdi_pkg::CfgW-1:0]           cfg_data_i,
  input  wire logic signed [sfdi_pkg::SampleBits-1:0] left_in_i,
  input  wire logic signed [sfdi_pkg::SampleBits-1:0] right_in_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [sfdi_pkg::SampleBits-1:0]   left_out_o,
  output logic signed [sfdi_pkg::SampleBits-1:0]   right_out_o
);

  localparam int S  = sfdi_pkg::SampleBits;
  localparam int AW = sfdi_pkg::AddrW;
  localparam int LW = sfdi_pkg::LenW;
  localparam int FW = sfdi_pkg::FracW;
  localparam int PW = sfdi_pkg::PosW;

  // Configuration registers.
  logic [15:0] dry_wet_q;
  logic [14:0] feedback_gain_q;
  logic [23:0] delay_target_q;
  logic [16:0] buffer_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_wet_q       <= sfdi_pkg::DryWetReset;
      feedback_gain_q <= sfdi_pkg::FeedbackReset;
      delay_target_q  <= sfdi_pkg::DelayTargetReset;
      buffer_length_q <= sfdi_pkg::BufferLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sfdi_pkg::CfgDryWet:    dry_wet_q       <= cfg_data_i[15:0];
        sfdi_pkg::CfgFeedback:  feedback_gain_q <= cfg_data_i[14:0];
        sfdi_pkg::CfgDelay:     delay_target_q  <= cfg_data_i[23:0];
        sfdi_pkg::CfgBufferLen: buffer_length_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // Per-beat state and working registers.
  logic [AW-1:0]             wp_q;
  logic [sfdi_pkg::SmW-1:0]  sm_q;
  logic signed [S-1:0]       fb_q [2];
  logic signed [S-1:0]       x_q [2];
  logic [LW-1:0]             len_q;
  logic [14:0]               gain_q;
  logic [15:0]               w_q;
  logic [sfdi_pkg::SmW-1:0]  mag_q;
  logic                      neg_q;
  logic [42:0]               plo_q;
  logic [34:0]               phi_q;
  logic [27:0]               step_q;
  logic [AW-1:0]             cur_q, nxt_q;
  logic [FW-1:0]             frac_q;
  logic signed [S-1:0]       a_q [2];
  logic signed [S+25:0]      p_q [2];
  logic signed [S-1:0]       dl_q [2];
  logic signed [S+15:0]      fbp_q [2];
  logic signed [S+17:0]      ma_q [2];
  logic signed [S+17:0]      mb_q [2];
  logic                      out_valid_q;
  logic signed [S-1:0]       out_q [2];

  // Load-time values.
  logic [LW-1:0]            len_cl;
  logic [sfdi_pkg::SmW-1:0] tgt_ext;
  logic                     neg_now;

  always_comb begin
    if (buffer_length_q < 17'd2) begin
      len_cl = LW'(32'd2);
    end else if (32'(buffer_length_q) > sfdi_pkg::BufferDepth) begin
      len_cl = LW'(sfdi_pkg::BufferDepth);
    end else begin
      len_cl = LW'(buffer_length_q);
    end
    tgt_ext = {delay_target_q, 16'b0};
    neg_now = tgt_ext < sm_q;
  end

  // Smoother step and read position.
  logic [59:0]       step_sum;
  logic [PW-1:0]     dmax, dsel, sm_ext;
  logic signed [PW-1:0] pos;
  logic [LW-1:0]     cur_full, nxt_full, wp_inc;

  always_comb begin
    step_sum = {17'b0, plo_q} + {1'b0, phi_q, 24'b0} + 60'h0_8000_0000;
    dmax     = PW'({len_q - 1'b1, {FW{1'b0}}});
    sm_ext   = PW'(sm_q);
    dsel     = (sm_ext > dmax) ? dmax : sm_ext;
    pos      = $signed(PW'({wp_q, {FW{1'b0}}})) - $signed(dsel);
    if (pos[PW-1]) begin
      pos = pos + $signed(PW'({len_q, {FW{1'b0}}}));
    end
    cur_full = pos[FW+LW-1:FW];
    nxt_full = {1'b0, cur_q} + 1'b1;
    wp_inc   = {1'b0, wp_q} + 1'b1;
  end

  // Delay-line RAMs, one per channel.
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic                ram_we;
  logic [S-1:0]        ram_wdata [2];
  logic signed [S-1:0] rdata [2];

  assign ram_we    = cmd_i.clr_we | cmd_i.wr;
  assign ram_waddr = cmd_i.clr_we ? cmd_i.clr_addr : wp_q;
  assign ram_raddr = cmd_i.rda ? cur_q : nxt_q;

  for (genvar c = 0; c < 2; c++) begin : g_lane
    logic [S-1:0] rd;
    assign ram_wdata[c] = cmd_i.clr_we ? '0 :
        sfdi_pkg::sat_fn({{4{x_q[c][S-1]}}, x_q[c]} + {{4{fb_q[c][S-1]}}, fb_q[c]});
    assign rdata[c] = $signed(rd);

    sfdi_ram #(.Width(S), .Depth(sfdi_pkg::BufferDepth)) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .waddr_i (ram_waddr),
      .wdata_i (ram_wdata[c]),
      .raddr_i (ram_raddr),
      .rdata_o (rd)
    );

    logic signed [S:0]    diff_ba;
    logic signed [S+25:0] p_rnd;
    logic signed [S+15:0] fb_rnd;
    logic signed [S+18:0] mix_sum;

    always_comb begin
      diff_ba = $signed({rdata[c][S-1], rdata[c]}) - $signed({a_q[c][S-1], a_q[c]});
      p_rnd   = (p_q[c] + (S+26)'(32'sd8388608)) >>> FW;
      fb_rnd  = (fbp_q[c] + (S+16)'(32'sd16384)) >>> 15;
      mix_sum = ((S+19)'(ma_q[c]) + (S+19)'(mb_q[c]) + (S+19)'(32'sd16384)) >>> 15;
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        x_q[c] <= (c == 0) ? left_in_i : right_in_i;
      end
      if (cmd_i.rdb) begin
        a_q[c] <= rdata[c];
      end
      if (cmd_i.intp) begin
        p_q[c] <= diff_ba * $signed({1'b0, frac_q});
      end
      if (cmd_i.dly) begin
        dl_q[c] <= a_q[c] + p_rnd[S-1:0];
      end
      if (cmd_i.mix) begin
        fbp_q[c] <= dl_q[c] * $signed({1'b0, gain_q});
        ma_q[c]  <= x_q[c] * $signed({1'b0, 17'(sfdi_pkg::MixFull) - 17'(w_q)});
        mb_q[c]  <= (S+18)'(dl_q[c] * $signed({1'b0, w_q}));
      end
      if (cmd_i.fin) begin
        out_q[c] <= sfdi_pkg::sat_fn(mix_sum[S+3:0]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fb_q[c] <= '0;
      end else if (cmd_i.fin) begin
        fb_q[c] <= fb_rnd[S-1:0];
      end
    end
  end

  // Working registers shared by both channels.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      len_q  <= len_cl;
      gain_q <= (feedback_gain_q > sfdi_pkg::FeedbackMax) ? sfdi_pkg::FeedbackMax
                                                          : feedback_gain_q;
      w_q    <= (dry_wet_q > sfdi_pkg::MixFull) ? sfdi_pkg::MixFull : dry_wet_q;
      neg_q  <= neg_now;
      mag_q  <= neg_now ? (sm_q - tgt_ext) : (tgt_ext - sm_q);
    end
    if (cmd_i.wr) begin
      plo_q <= 43'(mag_q[23:0] * sfdi_pkg::SmoothK);
    end
    if (cmd_i.mul_hi) begin
      phi_q <= 35'(mag_q[39:24] * sfdi_pkg::SmoothK);
    end
    if (cmd_i.step) begin
      step_q <= step_sum[59:32];
    end
    if (cmd_i.pos) begin
      cur_q  <= (cur_full >= len_q) ? '0 : cur_full[AW-1:0];
      frac_q <= pos[FW-1:0];
    end
    if (cmd_i.rda) begin
      nxt_q <= (nxt_full >= len_q) ? '0 : nxt_full[AW-1:0];
    end
  end

  // Write position, smoothed delay and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      sm_q        <= {sfdi_pkg::DelayTargetReset, 16'b0};
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load && ({1'b0, wp_q} >= len_cl)) begin
        wp_q <= '0;
      end else if (cmd_i.fin) begin
        wp_q <= (wp_inc >= len_q) ? '0 : wp_inc[AW-1:0];
      end
      if (cmd_i.smooth) begin
        sm_q <= neg_q ? (sm_q - {12'b0, step_q}) : (sm_q + {12'b0, step_q});
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign left_out_o  = out_q[0];
  assign right_out_o = out_q[1];

endmodule
`default_nettype wire
